### rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// Shared types, S-box tables and byte-level helpers for the AES-128 CBC block.
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam int unsigned NumRounds = 10;
   localparam int unsigned RkEntries = 2 * (NumRounds + 1);

   typedef logic [127:0] block_type;
   typedef logic [3:0]   round_type;
   typedef logic [2:0]   csr_addr_type;

   localparam csr_addr_type CSR_DECRYPT_MODE = 3'd0;
   localparam csr_addr_type CSR_KEY_HI       = 3'd1;
   localparam csr_addr_type CSR_KEY_LO       = 3'd2;
   localparam csr_addr_type CSR_IV_HI        = 3'd3;
   localparam csr_addr_type CSR_IV_LO        = 3'd4;

   // control from sequencer to round unit
   typedef struct packed {
      logic      load;     // load state with first key addition
      logic      step;     // run one round
      logic      last;     // final round (no mix)
      logic      decrypt;
      round_type round;    // key index used this cycle
   } round_ctl_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // byte i of a block sits at bits 127-8i
   function automatic logic [7:0] get_byte(input block_type b, input int i);
      return b[127 - 8*i -: 8];
   endfunction

   function automatic block_type sub_shift(input block_type b);
      block_type t;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[127 - 8*(c*4+r) -: 8] = SBOX[get_byte(b, ((c + r) % 4) * 4 + r)];
      return t;
   endfunction

   function automatic block_type inv_shift_sub(input block_type b);
      block_type t;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[127 - 8*(((c + r) % 4)*4 + r) -: 8] = INV_SBOX[get_byte(b, c*4 + r)];
      return t;
   endfunction

   function automatic block_type mix_cols(input block_type b);
      block_type t;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(b, c*4);
         a1 = get_byte(b, c*4+1);
         a2 = get_byte(b, c*4+2);
         a3 = get_byte(b, c*4+3);
         t[127 - 8*(c*4)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         t[127 - 8*(c*4+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         t[127 - 8*(c*4+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         t[127 - 8*(c*4+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return t;
   endfunction

   // inverse mix as a pre-multiply by {05,00,04,00} followed by forward mix
   function automatic block_type inv_mix_cols(input block_type b);
      block_type t;
      logic [7:0] a0, a1, a2, a3, u, v;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(b, c*4);
         a1 = get_byte(b, c*4+1);
         a2 = get_byte(b, c*4+2);
         a3 = get_byte(b, c*4+3);
         u = xtime(xtime(a0 ^ a2));
         v = xtime(xtime(a1 ^ a3));
         t[127 - 8*(c*4)   -: 8] = a0 ^ u;
         t[127 - 8*(c*4+1) -: 8] = a1 ^ v;
         t[127 - 8*(c*4+2) -: 8] = a2 ^ u;
         t[127 - 8*(c*4+3) -: 8] = a3 ^ v;
      end
      return mix_cols(t);
   endfunction

endpackage

### rtl/aes_stream_if.sv
// ----------------------------------------------------------------------------
// AES channel interfaces
// Valid/ready channels for blocks, results and register writes.
// ----------------------------------------------------------------------------
interface aes_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_hi;
   logic [63:0] block_lo;
   logic        start_of_message;
   modport source (output valid, block_hi, block_lo, start_of_message, input ready);
   modport sink   (input valid, block_hi, block_lo, start_of_message, output ready);
endinterface

interface aes_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_hi;
   logic [63:0] result_lo;
   modport source (output valid, result_hi, result_lo, input ready);
   modport sink   (input valid, result_hi, result_lo, output ready);
endinterface

interface aes_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/aes_key_sched.sv
// ----------------------------------------------------------------------------
// AES key schedule
// Expands the key one round key per cycle into a 22x64 store.
// ----------------------------------------------------------------------------
module aes_key_sched (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,     // key register written
   input  logic [127:0]          key,
   input  aes_pkg::round_type    rd_round,
   output logic [127:0]          rd_key,
   output logic                  busy
);
   import aes_pkg::*;

   logic [63:0]  store_ff [RkEntries];
   logic [127:0] prev_ff, prev_in;
   round_type    cnt_ff, cnt_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic         busy_ff, busy_in;
   logic         restart_ff, restart_in;
   logic [31:0]  w0, w1, w2, w3, t;
   logic         wr_en;
   logic [127:0] wr_data;
   logic [4:0]   wr_idx;

   // a write during expansion restarts it from the new key
   always_comb begin
      t  = sub_word({prev_ff[23:0], prev_ff[31:24]}) ^ {rcon_ff, 24'h0};
      w0 = prev_ff[127:96] ^ t;
      w1 = prev_ff[95:64] ^ w0;
      w2 = prev_ff[63:32] ^ w1;
      w3 = prev_ff[31:0] ^ w2;
      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      prev_in    = prev_ff;
      rcon_in    = rcon_ff;
      restart_in = 1'b0;
      wr_en      = 1'b0;
      wr_data    = key;
      wr_idx     = 5'd0;
      if (restart_ff) begin
         wr_en   = 1'b1;
         prev_in = key;
         cnt_in  = 4'd1;
         rcon_in = 8'h01;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         wr_en   = 1'b1;
         wr_data = {w0, w1, w2, w3};
         wr_idx  = {cnt_ff, 1'b0};
         prev_in = {w0, w1, w2, w3};
         rcon_in = xtime(rcon_ff);
         cnt_in  = cnt_ff + 4'd1;
         if (cnt_ff == round_type'(NumRounds)) busy_in = 1'b0;
      end
      if (start) begin
         restart_in = 1'b1;
         busy_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         restart_ff <= 1'b1;
         cnt_ff     <= '0;
         rcon_ff    <= 8'h01;
      end else begin
         busy_ff    <= busy_in;
         restart_ff <= restart_in;
         cnt_ff     <= cnt_in;
         rcon_ff    <= rcon_in;
      end
      prev_ff <= prev_in;
      if (wr_en) begin
         store_ff[wr_idx]        <= wr_data[127:64];
         store_ff[wr_idx + 5'd1] <= wr_data[63:0];
      end
   end

   assign rd_key = {store_ff[{rd_round, 1'b0}], store_ff[{rd_round, 1'b1}]};
   assign busy   = busy_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !restart_ff |-> cnt_ff <= round_type'(NumRounds))
      else $error("key schedule counter out of range");
   a_restart_busy: assert property (@(posedge clock) disable iff (reset)
      restart_ff |-> busy_ff)
      else $error("restart without busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("key write did not start expansion");
endmodule

### rtl/aes_round_unit.sv
// ----------------------------------------------------------------------------
// AES round unit
// One shared round datapath, encrypt or decrypt, reused for all ten rounds.
// ----------------------------------------------------------------------------
module aes_round_unit (
   input  logic                  clock,
   input  aes_pkg::round_ctl_type ctl,
   input  logic [127:0]          load_data,
   input  logic [127:0]          round_key,
   output logic [127:0]          state
);
   import aes_pkg::*;

   block_type state_ff, state_in, sub_out, enc_mix, dec_mix;

   always_comb begin
      sub_out = ctl.decrypt ? inv_shift_sub(state_ff) : sub_shift(state_ff);
      enc_mix = ctl.last ? sub_out : mix_cols(sub_out);
      dec_mix = ctl.last ? (sub_out ^ round_key) : inv_mix_cols(sub_out ^ round_key);
      state_in = state_ff;
      if (ctl.load) begin
         state_in = load_data ^ round_key;
      end else if (ctl.step) begin
         state_in = ctl.decrypt ? dec_mix : (enc_mix ^ round_key);
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign state = state_ff;
endmodule

### rtl/aes128_cbc_block_cipher.sv
// ----------------------------------------------------------------------------
// AES-128 CBC block cipher
// Iterative AES-128 with CBC chaining, one round per cycle.
// ----------------------------------------------------------------------------
// Usage:
//  - csr: register writes (0 decrypt_mode, 1 key_hi, 2 key_lo, 3 iv_hi,
//    4 iv_lo); higher indexes are ignored. Writing a key word re-expands
//    the round keys, one round key per cycle; requests are held off after
//    the write until the expansion is done.
//  - req: one 128-bit block per transaction; start_of_message reloads the
//    chaining value from the IV registers first.
//  - rsp: one result block per request.
// Timing: a request is accepted when idle and no key expansion is pending;
//  the shared round unit does the initial key addition in the accept cycle
//  plus ten rounds, one per cycle, and then holds the result valid. A new
//  request is taken the cycle after the result leaves, so a new block is
//  not accepted before the previous result has been taken.
// Reset: round keys are re-expanded from the all-zero key (no request taken
//  meanwhile); chaining value and registers clear to zero.
// Stall: the result is held in its register until taken; no new request
//  is accepted until then.
// ----------------------------------------------------------------------------
module aes128_cbc_block_cipher (
   input logic clock,
   input logic reset,
   aes_req_if.sink   req,
   aes_rsp_if.source rsp,
   aes_csr_if.sink   csr
);
   import aes_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

   state_type     st_ff, st_in;
   round_type     rnd_ff, rnd_in;
   logic          dec_ff;
   logic [127:0]  key_ff, iv_ff, chain_ff, cin_ff;
   logic [127:0]  chain_eff, in_blk, rk, ru_state, dec_out;
   logic          ks_busy, key_wr, req_fire, key_wr_ff;
   round_ctl_type ctl;

   assign csr.ready = 1'b1;
   assign key_wr = csr.valid && (csr.index == CSR_KEY_HI || csr.index == CSR_KEY_LO);
   // hold off during the cycle between a key write and the expansion start
   assign req.ready = (st_ff == ST_IDLE) && !ks_busy && !key_wr_ff;
   assign req_fire  = req.valid && req.ready;
   assign in_blk    = {req.block_hi, req.block_lo};
   assign chain_eff = req.start_of_message ? iv_ff : chain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff <= 1'b0;
         key_ff <= '0;
         iv_ff  <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_DECRYPT_MODE: dec_ff <= csr.data[0];
            CSR_KEY_HI:       key_ff[127:64] <= csr.data;
            CSR_KEY_LO:       key_ff[63:0] <= csr.data;
            CSR_IV_HI:        iv_ff[127:64] <= csr.data;
            CSR_IV_LO:        iv_ff[63:0] <= csr.data;
            default: ;
         endcase
      end
   end

   // expansion starts the cycle after the key register is updated
   always_ff @(posedge clock) begin
      if (reset) key_wr_ff <= 1'b0;
      else       key_wr_ff <= key_wr;
   end

   aes_key_sched u_ks (
      .clock    (clock),
      .reset    (reset),
      .start    (key_wr_ff),
      .key      (key_ff),
      .rd_round (ctl.round),
      .rd_key   (rk),
      .busy     (ks_busy)
   );

   always_comb begin
      ctl.load    = req_fire;
      ctl.step    = (st_ff == ST_RUN);
      ctl.decrypt = dec_ff;
      ctl.last    = (rnd_ff == round_type'(NumRounds));
      if (req_fire)
         ctl.round = dec_ff ? round_type'(NumRounds) : round_type'(0);
      else
         ctl.round = dec_ff ? round_type'(NumRounds) - rnd_ff : rnd_ff;
   end

   aes_round_unit u_ru (
      .clock     (clock),
      .ctl       (ctl),
      .load_data (dec_ff ? in_blk : (in_blk ^ chain_eff)),
      .round_key (rk),
      .state     (ru_state)
   );

   assign dec_out = ru_state ^ chain_ff;

   always_comb begin
      st_in  = st_ff;
      rnd_in = rnd_ff;
      case (st_ff)
         ST_IDLE: if (req_fire) begin
            st_in  = ST_RUN;
            rnd_in = 4'd1;
         end
         ST_RUN: begin
            rnd_in = rnd_ff + 4'd1;
            if (ctl.last) st_in = ST_OUT;
         end
         ST_OUT: if (rsp.ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         rnd_ff   <= '0;
         chain_ff <= '0;
      end else begin
         st_ff  <= st_in;
         rnd_ff <= rnd_in;
         if (req_fire) begin
            // decrypt: chain holds value to XOR at the end, cin holds next
            chain_ff <= chain_eff;
            cin_ff   <= in_blk;
         end else if (st_ff == ST_RUN && ctl.last && dec_ff) begin
            chain_ff <= chain_ff;
         end else if (st_ff == ST_OUT && rsp.ready) begin
            chain_ff <= dec_ff ? cin_ff : ru_state;
         end
      end
   end

   assign rsp.valid     = (st_ff == ST_OUT);
   assign rsp.result_hi = dec_ff ? dec_out[127:64] : ru_state[127:64];
   assign rsp.result_lo = dec_ff ? dec_out[63:0]   : ru_state[63:0];

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != ST_IDLE |-> !req_fire)
      else $error("request accepted while busy");
   a_run_len: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> ##11 rsp.valid)
      else $error("result not ready after eleven cycles");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(st_ff))
      else $error("state register not one-hot");
   a_no_ks_overlap: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !ks_busy)
      else $error("request accepted during key expansion");
endmodule
